@@ rtl/kts_pkg.sv @@
// kts_pkg: types, codes and constants of the keyframe track sampler.
// No dependencies; compiled first.
package kts_pkg;

    localparam int MAX_KEYS_DEF = 64;
    localparam int VAL_W        = 32;
    localparam int SEG_W        = 6;
    localparam int FRAC_W       = 17;

    typedef enum logic [1:0] {
        OP_APPEND = 2'd0,
        OP_SAMPLE = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef struct packed {
        logic [1:0]        op;
        logic signed [31:0] key_time;
        logic signed [31:0] key_x;
        logic signed [31:0] key_y;
        logic signed [31:0] key_z;
        logic signed [31:0] sample_time;
    } in_item_t;

    typedef struct packed {
        logic [1:0]        status;
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic [5:0]        segment;
    } out_item_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD0,
        S_CHK0,
        S_SRD,
        S_SCMP,
        S_DIV,
        S_MUL,
        S_LRD,
        S_LOUT,
        S_OUT
    } state_t;

endpackage

@@ rtl/kts_if.sv @@
// kts_if: valid/ready channel carrying one payload.
// Depends on nothing; payload type given by parameter.
interface kts_if #(parameter type payload_t = logic) ();
    logic     valid;
    logic     ready;
    payload_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/kts_ram.sv @@
// kts_ram: generic single-port-write, single-read RAM with registered read.
// No dependencies.
module kts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

@@ rtl/kts_div.sv @@
// kts_div: restoring divider, one quotient bit per cycle, floor(dt*2^16/span).
// Depends on kts_pkg.
module kts_div (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [32:0]          dt,
    input  logic [32:0]          span,
    output logic [kts_pkg::FRAC_W-1:0] quot,
    output logic                 done
);
    import kts_pkg::*;

    logic [33:0]       rem_reg, rem_next;
    logic [16:0]       q_reg, q_next;
    logic [32:0]       d_reg, d_next;
    logic [4:0]        cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic [33:0]       trial;

    // dt <= span holds, so the quotient fits 17 bits; start remainder at dt
    always_comb
    begin
        rem_next  = rem_reg;
        q_next    = q_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        trial     = {rem_reg[32:0], 1'b0} - {1'b0, d_reg};
        done      = 1'b0;
        if (start)
        begin
            busy_next = (span != 33'd0);
            done      = (span == 33'd0);
            rem_next  = {1'b0, dt};
            q_next    = 17'd0;
            d_next    = span;
            cnt_next  = 5'd0;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == 5'd0)
            begin
                // integer bit: dt >= span
                if (rem_reg >= {1'b0, d_reg})
                begin
                    rem_next = rem_reg - {1'b0, d_reg};
                    q_next   = 17'd1;
                end
            end
            else if (!trial[33])
            begin
                rem_next = trial;
                q_next   = {q_reg[15:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[32:0], 1'b0};
                q_next   = {q_reg[15:0], 1'b0};
            end
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd16)
            begin
                busy_next = 1'b0;
                done      = 1'b1;
            end
        end
    end

    assign quot = q_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= 5'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        q_reg   <= q_next;
        d_reg   <= d_next;
    end
endmodule

@@ rtl/keyframe_track_sampler_core.sv @@
// keyframe_track_sampler_core: top level of the keyframe track sampler.
// Depends on kts_pkg, kts_if, kts_ram and kts_div.
//
// Usage:
//   Commands arrive on in_ch (append a key, sample at a time, clear the track,
//   or an unused code); each accepted transaction yields exactly one result
//   transaction on out_ch carrying status, the sampled vector and segment.
//   Keys are stored in four RAMs (time, x, y, z) with a registered read port.
//   Append, clear, unused codes and a sample of an empty track go straight to
//   the output state. Any other sample reads key 0, then, unless it lies at or
//   before key 0 or the track holds one key, scans segments through the RAM
//   read port; past the last key it returns that key. On a hit it runs the
//   bit-serial divider (skipped for a zero-length segment) and the three
//   interpolation multiplies through one shared multiplier.
//   in_ch.ready is high only in the idle state; one command is in work.
//   A finished result sits in the output register until out_ch.ready; the
//   block holds in that state while the receiver stalls.
//   Reset empties the track (key count zero); RAM contents are left as is.
module keyframe_track_sampler_core #(
    parameter int MAX_KEYS = kts_pkg::MAX_KEYS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    kts_if.sink   in_ch,
    kts_if.source out_ch
);
    import kts_pkg::*;

    localparam int AW = $clog2(MAX_KEYS);
    localparam int CW = $clog2(MAX_KEYS + 1);

    state_t            state_reg, state_next;
    in_item_t          cmd_reg;
    logic [CW-1:0]     count_reg, count_next;
    logic [AW-1:0]     idx_reg, idx_next;
    logic [AW-1:0]     raddr;
    out_item_t         res_reg, res_next;
    logic [1:0]        lane_reg, lane_next;
    logic [16:0]       frac_reg;

    // RAM read data
    logic signed [31:0] rd_t, rd_x, rd_y, rd_z;
    // previous key (segment start) held across the scan
    logic signed [31:0] t0_reg, x0_reg, y0_reg, z0_reg;
    logic signed [31:0] t1_reg, x1_reg, y1_reg, z1_reg;

    logic we;
    assign we = (state_reg == S_IDLE) && in_ch.valid && (in_ch.data.op == OP_APPEND)
                && (count_reg < CW'(MAX_KEYS));

    kts_ram #(.WIDTH(32), .DEPTH(MAX_KEYS)) u_ram_t (.clk, .we,
        .waddr(count_reg[AW-1:0]), .wdata(in_ch.data.key_time), .raddr, .rdata(rd_t));
    kts_ram #(.WIDTH(32), .DEPTH(MAX_KEYS)) u_ram_x (.clk, .we,
        .waddr(count_reg[AW-1:0]), .wdata(in_ch.data.key_x), .raddr, .rdata(rd_x));
    kts_ram #(.WIDTH(32), .DEPTH(MAX_KEYS)) u_ram_y (.clk, .we,
        .waddr(count_reg[AW-1:0]), .wdata(in_ch.data.key_y), .raddr, .rdata(rd_y));
    kts_ram #(.WIDTH(32), .DEPTH(MAX_KEYS)) u_ram_z (.clk, .we,
        .waddr(count_reg[AW-1:0]), .wdata(in_ch.data.key_z), .raddr, .rdata(rd_z));

    // divider; started in the compare cycle, so the span is taken from
    // the segment end still on the RAM read port
    logic              div_start;
    logic              div_busy;
    logic              div_done;
    logic [16:0]       div_q;
    logic [32:0]       dt_w, span_w;
    assign dt_w   = 33'(signed'(cmd_reg.sample_time)) - 33'(signed'(t0_reg));
    assign span_w = 33'(signed'(rd_t)) - 33'(signed'(t0_reg));
    assign div_busy = (state_reg == S_DIV);

    kts_div u_div (.clk, .rst_n, .start(div_start), .dt(dt_w), .span(span_w),
        .quot(div_q), .done(div_done));

    // shared multiplier: 33-bit signed difference by 17-bit fraction
    logic signed [31:0] m_v0, m_v1;
    logic signed [32:0] m_diff;
    logic signed [50:0] m_prod;
    logic signed [31:0] m_res;
    always_comb
    begin
        unique case (lane_reg)
            2'd0:    begin m_v0 = x0_reg; m_v1 = x1_reg; end
            2'd1:    begin m_v0 = y0_reg; m_v1 = y1_reg; end
            default: begin m_v0 = z0_reg; m_v1 = z1_reg; end
        endcase
        m_diff = 33'(m_v1) - 33'(m_v0);
        m_prod = 51'(m_diff) * 51'(signed'({1'b0, frac_reg})) + 51'sd32768;
        // round half up, then shift; result lies between v0 and v1
        m_res  = m_v0 + 32'(m_prod >>> 16);
    end

    logic sc_hit;
    assign sc_hit = (t0_reg <= cmd_reg.sample_time) && (cmd_reg.sample_time <= rd_t);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (in_ch.valid)
                    state_next = (in_ch.data.op == OP_SAMPLE && count_reg != '0) ? S_RD0 : S_OUT;
            S_RD0:   state_next = S_CHK0;
            S_CHK0:
                if (count_reg == CW'(1) || cmd_reg.sample_time <= rd_t)
                    state_next = S_OUT;
                else
                    state_next = S_SRD;
            S_SRD:   state_next = S_SCMP;
            S_SCMP:
                if (sc_hit)
                    // a zero-length segment finishes the divide at once
                    state_next = div_done ? S_MUL : S_DIV;
                else if (CW'(idx_reg) + CW'(1) >= count_reg - CW'(1))
                    state_next = S_LRD;
                else
                    state_next = S_SRD;
            S_DIV:   if (div_done) state_next = S_MUL;
            S_MUL:   if (lane_reg == 2'd2) state_next = S_OUT;
            S_LRD:   state_next = S_LOUT;
            S_LOUT:  state_next = S_OUT;
            S_OUT:   if (out_ch.ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // outputs and datapath controls
    always_comb
    begin
        idx_next      = idx_reg;
        lane_next     = lane_reg;
        res_next      = res_reg;
        count_next    = count_reg;
        raddr         = idx_reg;
        div_start     = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                res_next = '0;
                idx_next = '0;
                raddr    = '0;
                if (in_ch.valid)
                begin
                    unique case (in_ch.data.op)
                        OP_APPEND:
                            if (we) count_next = count_reg + CW'(1);
                            else    res_next.status = ST_FULL;
                        OP_CLEAR:  count_next = '0;
                        OP_SAMPLE: if (count_reg == '0) res_next.status = ST_EMPTY;
                        default:   ;
                    endcase
                end
            end
            S_CHK0:
            begin
                res_next.out_x = rd_x;
                res_next.out_y = rd_y;
                res_next.out_z = rd_z;
            end
            S_SRD:   raddr = idx_reg + AW'(1);
            S_SCMP:
            begin
                raddr = idx_reg + AW'(1);
                if (sc_hit)
                begin
                    div_start     = 1'b1;
                    lane_next     = 2'd0;
                    res_next.segment = 6'(idx_reg);
                end
                else
                    idx_next = idx_reg + AW'(1);
            end
            S_MUL:
            begin
                lane_next = lane_reg + 2'd1;
                unique case (lane_reg)
                    2'd0:    res_next.out_x = m_res;
                    2'd1:    res_next.out_y = m_res;
                    default: res_next.out_z = m_res;
                endcase
            end
            S_LRD:   raddr = AW'(count_reg - CW'(1));
            S_LOUT:
            begin
                raddr = AW'(count_reg - CW'(1));
                res_next.out_x   = rd_x;
                res_next.out_y   = rd_y;
                res_next.out_z   = rd_z;
                res_next.segment = 6'(count_reg - CW'(1));
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    // payload registers; hold the segment start and end across the scan
    always_ff @(posedge clk)
    begin
        res_reg  <= res_next;
        idx_reg  <= idx_next;
        lane_reg <= lane_next;
        if (state_reg == S_IDLE && in_ch.valid)
            cmd_reg <= in_ch.data;
        if (state_reg == S_CHK0 || (state_reg == S_SCMP && !sc_hit))
        begin
            t0_reg <= rd_t; x0_reg <= rd_x; y0_reg <= rd_y; z0_reg <= rd_z;
        end
        if (state_reg == S_SCMP && sc_hit)
        begin
            t1_reg <= rd_t; x1_reg <= rd_x; y1_reg <= rd_y; z1_reg <= rd_z;
        end
        if (div_done)
            frac_reg <= div_q;
    end

    assign in_ch.ready  = (state_reg == S_IDLE);
    assign out_ch.valid = (state_reg == S_OUT);
    assign out_ch.data  = res_reg;

    // the key count never exceeds the table
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_KEYS)) else $error("key count beyond table");
    // a result is offered only after a command was taken
    a_out_after_in: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_ch.valid) |-> !in_ch.ready) else $error("result without command");
    // the divider finishes only while the sequencer waits on it
    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (div_busy || div_start)) else $error("stray divide");
endmodule

@@ tb/tb.sv @@
// tb: self-checking testbench for keyframe_track_sampler_core.
// Depends on kts_pkg, kts_if and the core RTL; drives commands, predicts each
// result in-line and compares every field in order.
`timescale 1ns / 100ps

module tb;
    import kts_pkg::*;

    localparam int N_RANDOM = 1300;
    localparam int KEYS     = MAX_KEYS_DEF;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    always #10 clk = ~clk;

    kts_if #(.payload_t(in_item_t))  cmd_ch ();
    kts_if #(.payload_t(out_item_t)) res_ch ();

    keyframe_track_sampler_core u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (cmd_ch.sink),
        .out_ch (res_ch.source)
    );

    // Predictor state: a private copy of the key table
    logic signed [31:0] trk_time [KEYS];
    logic signed [31:0] trk_x    [KEYS];
    logic signed [31:0] trk_y    [KEYS];
    logic signed [31:0] trk_z    [KEYS];
    int unsigned        trk_count;

    out_item_t expected_results[$];
    int        error_count;
    int        result_count;
    int        sample_count;
    int        full_count;
    int        empty_count;
    logic      long_stall;

    // Blend two values by a 17-bit fraction, rounding half up
    function automatic logic signed [31:0] blend(input logic signed [31:0] v0,
                                                input logic signed [31:0] v1,
                                                input logic [16:0] f);
        logic signed [63:0] diff;
        logic signed [63:0] prod;
        diff = 64'(v1) - 64'(v0);
        prod = diff * $signed({47'd0, f}) + 64'sd32768;
        return 32'(64'(v0) + (prod >>> 16));
    endfunction

    // Apply one command to the track copy and return its result
    function automatic out_item_t track_step(input in_item_t c);
        out_item_t          r;
        logic signed [31:0] t0, t1;
        logic [63:0]        dt, span;
        logic [16:0]        f;
        logic               found;
        int unsigned        seg;
        r = '0;
        found = 1'b0;
        case (op_t'(c.op))
            OP_APPEND:
            begin
                if (trk_count >= KEYS)
                    r.status = ST_FULL;
                else
                begin
                    trk_time[trk_count] = c.key_time;
                    trk_x[trk_count] = c.key_x;
                    trk_y[trk_count] = c.key_y;
                    trk_z[trk_count] = c.key_z;
                    trk_count++;
                end
            end
            OP_CLEAR: trk_count = 0;
            OP_SAMPLE:
            begin
                if (trk_count == 0)
                    r.status = ST_EMPTY;
                else if (trk_count == 1 || c.sample_time <= trk_time[0])
                begin
                    r.out_x = trk_x[0];
                    r.out_y = trk_y[0];
                    r.out_z = trk_z[0];
                end
                else
                begin
                    for (int i = 0; i + 1 < trk_count; i++)
                    begin
                        t0 = trk_time[i];
                        t1 = trk_time[i + 1];
                        if (!found && t0 <= c.sample_time && c.sample_time <= t1)
                        begin
                            dt = 64'(64'(c.sample_time) - 64'(t0));
                            span = 64'(64'(t1) - 64'(t0));
                            f = (span != 0) ? 17'((dt << 16) / span) : 17'd0;
                            r.out_x = blend(trk_x[i], trk_x[i + 1], f);
                            r.out_y = blend(trk_y[i], trk_y[i + 1], f);
                            r.out_z = blend(trk_z[i], trk_z[i + 1], f);
                            seg = i;
                            r.segment = 6'(seg);
                            found = 1'b1;
                        end
                    end
                    if (!found)
                    begin
                        seg = trk_count - 1;
                        r.out_x = trk_x[seg];
                        r.out_y = trk_y[seg];
                        r.out_z = trk_z[seg];
                        r.segment = 6'(seg);
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic in_item_t make_cmd(input op_t op, input logic [31:0] kt,
                                          input logic [31:0] kx,
                                          input logic [31:0] ky,
                                          input logic [31:0] kz,
                                          input logic [31:0] st);
        in_item_t c;
        c.op = op;
        c.key_time = kt;
        c.key_x = kx;
        c.key_y = ky;
        c.key_z = kz;
        c.sample_time = st;
        return c;
    endfunction

    // Directed table; a row with a typed expectation is also checked against it
    typedef struct {
        in_item_t  cmd;
        logic      has_fixed;
        out_item_t fixed;
    } dir_row_t;

    dir_row_t  dir_rows[$];
    int        burst_left;

    function automatic out_item_t fixed_res(input status_t s, input logic [31:0] x,
                                            input logic [31:0] y, input logic [31:0] z,
                                            input logic [5:0] seg);
        out_item_t r;
        r.status = s;
        r.out_x = x;
        r.out_y = y;
        r.out_z = z;
        r.segment = seg;
        return r;
    endfunction

    // Offer one transaction, with burst/gap idling, and record its expectation;
    // valid stays high after acceptance so back-to-back calls keep it steady
    task automatic send_cmd(input in_item_t c);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 6);
            if (gap != 0)
            begin
                cmd_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        cmd_ch.valid <= 1'b1;
        cmd_ch.data  <= c;
        @(posedge clk);
        while (!cmd_ch.ready)
            @(posedge clk);
        expected_results.push_back(track_step(c));
        if (op_t'(c.op) == OP_SAMPLE)
            sample_count++;
    endtask

    function automatic logic [31:0] rnd_val();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return $urandom_range(0, 2000) - 1000;
            default: return $urandom;
        endcase
    endfunction

    // Stimulus
    initial
    begin : stimulus
        in_item_t    c;
        logic [31:0] tcur;
        int          nkeys;
        int          sent;
        cmd_ch.valid = 1'b0;
        cmd_ch.data  = '0;
        burst_left   = 0;
        long_stall   = 1'b0;
        trk_count    = 0;
        error_count  = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty sample, extremes, zero-length segment, past-end, unused op
        dir_rows.push_back('{make_cmd(OP_SAMPLE, 0, 0, 0, 0, 0), 1'b1,
                             fixed_res(ST_EMPTY, 0, 0, 0, 0)});
        dir_rows.push_back('{make_cmd(OP_APPEND, 32'h8000_0000, 32'h8000_0000,
                             32'h7fff_ffff, 0, 0), 1'b1, fixed_res(ST_OK, 0, 0, 0, 0)});
        dir_rows.push_back('{make_cmd(OP_SAMPLE, 0, 0, 0, 0, 32'h7fff_ffff), 1'b1,
                             fixed_res(ST_OK, 32'h8000_0000, 32'h7fff_ffff, 0, 0)});
        dir_rows.push_back('{make_cmd(OP_APPEND, 32'h7fff_ffff, 32'h7fff_ffff,
                             32'h8000_0000, 32'hffff_ffff, 0), 1'b0, '0});
        dir_rows.push_back('{make_cmd(OP_SAMPLE, 0, 0, 0, 0, 32'h8000_0000), 1'b1,
                             fixed_res(ST_OK, 32'h8000_0000, 32'h7fff_ffff, 0, 0)});
        dir_rows.push_back('{make_cmd(OP_SAMPLE, 0, 0, 0, 0, 0), 1'b0, '0});
        dir_rows.push_back('{make_cmd(OP_SAMPLE, 0, 0, 0, 0, 32'h7fff_ffff), 1'b0, '0});
        dir_rows.push_back('{make_cmd(OP_SAMPLE, 0, 0, 0, 0, 32'h7fff_fffe), 1'b0, '0});
        dir_rows.push_back('{make_cmd(OP_APPEND, 32'h7fff_ffff, 5, 6, 7, 0), 1'b0, '0});
        dir_rows.push_back('{make_cmd(OP_APPEND, 32'h7fff_ffff, 1, 2, 3, 0), 1'b0, '0});
        dir_rows.push_back('{make_cmd(OP_SAMPLE, 0, 0, 0, 0, 32'h7fff_ffff), 1'b0, '0});
        dir_rows.push_back('{make_cmd(OP_NONE, 32'hffff_ffff, 32'hffff_ffff,
                             32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff), 1'b1,
                             fixed_res(ST_OK, 0, 0, 0, 0)});
        dir_rows.push_back('{make_cmd(OP_CLEAR, 0, 0, 0, 0, 0), 1'b1,
                             fixed_res(ST_OK, 0, 0, 0, 0)});
        dir_rows.push_back('{make_cmd(OP_SAMPLE, 0, 0, 0, 0, 5), 1'b1,
                             fixed_res(ST_EMPTY, 0, 0, 0, 0)});
        foreach (dir_rows[i])
        begin
            send_cmd(dir_rows[i].cmd);
            if (dir_rows[i].has_fixed && expected_results[$] != dir_rows[i].fixed)
            begin
                $display("%0t directed row %0d: expected %p, predicted %p", $time, i,
                         dir_rows[i].fixed, expected_results[$]);
                error_count++;
            end
        end

        // Fill the table beyond capacity while the receiver holds off
        long_stall <= 1'b1;
        for (int i = 0; i < KEYS + 3; i++)
            send_cmd(make_cmd(OP_APPEND, i * 100, $urandom, $urandom, $urandom, 0));
        long_stall <= 1'b0;
        send_cmd(make_cmd(OP_SAMPLE, 0, 0, 0, 0, 6350));
        // Pause the sender until every result is back
        cmd_ch.valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        send_cmd(make_cmd(OP_CLEAR, 0, 0, 0, 0, 0));

        // Random: mostly well-formed tracks with samples, some noise
        sent = 0;
        while (sent < N_RANDOM)
        begin
            nkeys = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 66)
                                                 : $urandom_range(1, 8);
            tcur = $urandom_range(0, 3) == 0 ? 32'h8000_0000 + $urandom_range(0, 9)
                                              : $urandom_range(0, 4000) - 2000;
            for (int k = 0; k < nkeys; k++)
            begin
                if ($urandom_range(0, 15) == 0)
                    c = make_cmd(OP_APPEND, $urandom, rnd_val(), rnd_val(), rnd_val(),
                                 $urandom);
                else
                begin
                    c = make_cmd(OP_APPEND, tcur, rnd_val(), rnd_val(), rnd_val(),
                                 $urandom);
                    case ($urandom_range(0, 3))
                        0: ;
                        1: tcur = tcur + $urandom_range(1, 3);
                        2: tcur = (tcur[31] == 1'b0 && $urandom_range(0, 1))
                                  ? 32'h7fff_ffff : tcur + $urandom_range(1, 70000);
                        default: tcur = tcur + $urandom_range(1, 300);
                    endcase
                end
                send_cmd(c);
                sent++;
            end
            repeat ($urandom_range(2, 8))
            begin
                case ($urandom_range(0, 9))
                    0: c = make_cmd(op_t'($urandom_range(0, 3)), $urandom, $urandom,
                                    $urandom, $urandom, $urandom);
                    1: c = make_cmd(OP_SAMPLE, $urandom, $urandom, $urandom, $urandom,
                                    $urandom);
                    default: c = make_cmd(OP_SAMPLE, $urandom, $urandom, $urandom,
                                          $urandom, tcur - $urandom_range(0, 80000));
                endcase
                send_cmd(c);
                sent++;
            end
            send_cmd(make_cmd(OP_CLEAR, $urandom, $urandom, $urandom, $urandom,
                              $urandom));
            sent++;
        end

        cmd_ch.valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        $display("Covered %0d results, %0d samples, %0d empty and %0d full rejections,",
                 result_count, sample_count, empty_count, full_count);
        $display("with bursty input, receiver stalls and one long output hold-off.");
        if (error_count == 0 && expected_results.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Receiver: own stall pattern, plus a long hold-off when asked
    initial
    begin : receiver
        int stall_cnt;
        res_ch.ready = 1'b0;
        stall_cnt = 0;
        forever
        begin
            @(posedge clk);
            if (long_stall && stall_cnt < 400)
            begin
                stall_cnt++;
                res_ch.ready <= 1'b0;
            end
            else
                res_ch.ready <= ($urandom_range(0, 99) < ((($time / 5000) % 3 == 0)
                                 ? 100 : 60));
        end
    end

    // Compare each accepted result with the oldest expectation
    always @(posedge clk)
    begin
        out_item_t got;
        out_item_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            got = res_ch.data;
            result_count++;
            if (expected_results.size() == 0)
            begin
                $display("%0t unexpected result: expected none, actual %p", $time, got);
                error_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (want.status == ST_FULL)
                    full_count++;
                if (want.status == ST_EMPTY)
                    empty_count++;
                if (got.status !== want.status)
                begin
                    $display("%0t status: expected %0d, actual %0d", $time,
                             want.status, got.status);
                    error_count++;
                end
                if (got.out_x !== want.out_x)
                begin
                    $display("%0t out_x: expected %h, actual %h", $time,
                             want.out_x, got.out_x);
                    error_count++;
                end
                if (got.out_y !== want.out_y)
                begin
                    $display("%0t out_y: expected %h, actual %h", $time,
                             want.out_y, got.out_y);
                    error_count++;
                end
                if (got.out_z !== want.out_z)
                begin
                    $display("%0t out_z: expected %h, actual %h", $time,
                             want.out_z, got.out_z);
                    error_count++;
                end
                if (got.segment !== want.segment)
                begin
                    $display("%0t segment: expected %0d, actual %0d", $time,
                             want.segment, got.segment);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        result_count = 0;
        sample_count = 0;
        full_count = 0;
        empty_count = 0;
    end

    // Overall time limit
    initial
    begin
        #(64'd200_000_000);
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/kts_pkg.sv
rtl/kts_if.sv
rtl/kts_ram.sv
rtl/kts_div.sv
rtl/keyframe_track_sampler_core.sv
tb/tb.sv
